/* sv/mko_pkg.sv */
// ---------------------------------------------------------------------------
// mko_pkg: shared types, constants and helpers
// Types, constants and small functions for the mecanum kinematics and
// odometry block.
// ---------------------------------------------------------------------------
`default_nettype none

package mko_pkg;

    // Formats and widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 20;
    localparam int DATA_W        = 32;
    localparam int TIME_W        = 48;
    localparam int DT_W          = 31;
    localparam int WIDE_W        = 64;
    localparam int PROD_W        = 128;
    localparam int DEN_W         = 24;
    localparam int ANG_W         = 34;
    localparam int CORDIC_N      = 24;
    localparam int CIDX_W        = 5;

    localparam logic [CFG_W-1:0]  RADIUS_RST    = 20'd4981;
    localparam logic [CFG_W-1:0]  BASE_RST      = 20'd26214;
    localparam logic [CFG_W-1:0]  TRACK_RST     = 20'd26214;
    localparam logic [WIDE_W-1:0] RAD_US_TO_BAM = 64'd2935890503282;
    localparam logic [ANG_W-1:0]  CORDIC_GAIN   = 34'd652032874;
    localparam logic [TIME_W-1:0] DT_MAX        = 48'h0000_7FFF_FFFF;

    // Divide by one million as multiply by ceil(2^83 / 1e6) and shift by 83;
    // exact for dividends below 2^63
    localparam logic [WIDE_W-1:0] RECIP_US = 64'd9671406556917033398;
    localparam int                RECIP_SH = 83;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_BASE   = 2'd1,
        REG_TRACK  = 2'd2
    } reg_idx_t;

    // Microsequence steps
    typedef enum logic [4:0] {
        ST_S, ST_W0, ST_W1, ST_W2, ST_W3,
        ST_VX, ST_VY, ST_OMM, ST_OMD, ST_COR,
        ST_XA, ST_XB, ST_YA, ST_YB,
        ST_PXM, ST_PXD, ST_PYM, ST_PYD,
        ST_HM, ST_HC
    } step_t;

    typedef enum logic [1:0] {
        U_MUL,
        U_DIV,
        U_COR
    } unit_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ISSUE,
        C_WAIT,
        C_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic  load_in;
        logic  start;
        logic  wb;
        logic  load_out;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic mul_busy;
        logic div_busy;
    } dp_stat_t;

    // Arctangent table, binary angle units
    function automatic logic [31:0] atan_bam(input logic [CIDX_W-1:0] i);
        case (i)
            5'd0:    return 32'd536870912;
            5'd1:    return 32'd316933406;
            5'd2:    return 32'd167458907;
            5'd3:    return 32'd85004756;
            5'd4:    return 32'd42667331;
            5'd5:    return 32'd21354465;
            5'd6:    return 32'd10679838;
            5'd7:    return 32'd5340245;
            5'd8:    return 32'd2670163;
            5'd9:    return 32'd1335087;
            5'd10:   return 32'd667544;
            5'd11:   return 32'd333772;
            5'd12:   return 32'd166886;
            5'd13:   return 32'd83443;
            5'd14:   return 32'd41722;
            5'd15:   return 32'd20861;
            5'd16:   return 32'd10430;
            5'd17:   return 32'd5215;
            5'd18:   return 32'd2608;
            5'd19:   return 32'd1304;
            5'd20:   return 32'd652;
            5'd21:   return 32'd326;
            5'd22:   return 32'd163;
            5'd23:   return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

    // Which shared unit a step runs on
    function automatic unit_t step_unit(input step_t s);
        case (s)
            ST_W0, ST_W1, ST_W2, ST_W3,
            ST_OMD:                 return U_DIV;
            ST_COR:                 return U_COR;
            default:                return U_MUL;
        endcase
    endfunction

    function automatic logic step_last(input step_t s);
        return (s == ST_W3) || (s == ST_HC);
    endfunction

    function automatic step_t step_succ(input step_t s);
        case (s)
            ST_S:    return ST_W0;
            ST_W0:   return ST_W1;
            ST_W1:   return ST_W2;
            ST_W2:   return ST_W3;
            ST_VX:   return ST_VY;
            ST_VY:   return ST_OMM;
            ST_OMM:  return ST_OMD;
            ST_OMD:  return ST_COR;
            ST_COR:  return ST_XA;
            ST_XA:   return ST_XB;
            ST_XB:   return ST_YA;
            ST_YA:   return ST_YB;
            ST_YB:   return ST_PXM;
            ST_PXM:  return ST_PXD;
            ST_PXD:  return ST_PYM;
            ST_PYM:  return ST_PYD;
            ST_PYD:  return ST_HM;
            ST_HM:   return ST_HC;
            default: return ST_S;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > $signed(64'h0000_0000_7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (v < $signed(64'hFFFF_FFFF_8000_0000))
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? $unsigned(-v) : $unsigned(v);
    endfunction

endpackage

`default_nettype wire

/* sv/mko_muldiv.sv */
// ---------------------------------------------------------------------------
// mko_muldiv: shared serial multiplier and divider
// Unsigned shift-add multiplier (one multiplier bit a cycle, stops early)
// and radix-2 restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module mko_muldiv
    import mko_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start_mul,
    input  wire logic [WIDE_W-1:0] mul_a,
    input  wire logic [WIDE_W-1:0] mul_b,
    output logic [PROD_W-1:0]      mul_p,
    output logic                   mul_done,
    output logic                   mul_busy,
    input  wire logic              start_div,
    input  wire logic [WIDE_W-1:0] div_n,
    input  wire logic [DEN_W-1:0]  div_d,
    output logic [WIDE_W-1:0]      div_q,
    output logic                   div_done,
    output logic                   div_busy
);

    localparam int CNT_W = $clog2(WIDE_W + 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(WIDE_W);

    logic [PROD_W-1:0] ma_reg, ma_next;
    logic [WIDE_W-1:0] mb_reg, mb_next;
    logic [PROD_W-1:0] mp_reg, mp_next;
    logic              mbusy_reg, mbusy_next;
    logic              mdone_reg, mdone_next;

    logic [WIDE_W-1:0] dn_reg, dn_next;
    logic [DEN_W-1:0]  dd_reg, dd_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              dbusy_reg, dbusy_next;
    logic              ddone_reg, ddone_next;
    logic [DEN_W:0]    rem_sh;
    logic              q_bit;

    // Multiplier: add shifted multiplicand for each set multiplier bit
    always_comb
    begin
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        mp_next    = mp_reg;
        mbusy_next = mbusy_reg;
        mdone_next = 1'b0;
        if (start_mul)
        begin
            ma_next    = {{(PROD_W-WIDE_W){1'b0}}, mul_a};
            mb_next    = mul_b;
            mp_next    = '0;
            mbusy_next = 1'b1;
        end
        else if (mbusy_reg)
        begin
            if (mb_reg == '0)
            begin
                mbusy_next = 1'b0;
                mdone_next = 1'b1;
            end
            else
            begin
                if (mb_reg[0])
                    mp_next = mp_reg + ma_reg;
                ma_next = ma_reg << 1;
                mb_next = mb_reg >> 1;
            end
        end
    end

    // Divider: one quotient bit per cycle
    always_comb
    begin
        dn_next    = dn_reg;
        dd_next    = dd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        dbusy_next = dbusy_reg;
        ddone_next = 1'b0;
        rem_sh     = {rem_reg, dn_reg[WIDE_W-1]};
        q_bit      = (rem_sh >= {1'b0, dd_reg});
        if (start_div)
        begin
            dn_next    = div_n;
            dd_next    = div_d;
            rem_next   = '0;
            cnt_next   = DIV_STEPS;
            dbusy_next = 1'b1;
        end
        else if (dbusy_reg)
        begin
            if (cnt_reg == '0)
            begin
                dbusy_next = 1'b0;
                ddone_next = 1'b1;
            end
            else
            begin
                if (q_bit)
                    rem_next = DEN_W'(rem_sh - {1'b0, dd_reg});
                else
                    rem_next = rem_sh[DEN_W-1:0];
                dn_next  = {dn_reg[WIDE_W-2:0], q_bit};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
        end
        else
        begin
            mbusy_reg <= mbusy_next;
            mdone_reg <= mdone_next;
            dbusy_reg <= dbusy_next;
            ddone_reg <= ddone_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        mp_reg  <= mp_next;
        dn_reg  <= dn_next;
        dd_reg  <= dd_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign mul_p    = mp_reg;
    assign mul_done = mdone_reg;
    assign mul_busy = mbusy_reg;
    assign div_q    = dn_reg;
    assign div_done = ddone_reg;
    assign div_busy = dbusy_reg;

endmodule

`default_nettype wire

/* sv/mko_cordic.sv */
// ---------------------------------------------------------------------------
// mko_cordic: iterative sine and cosine
// Rotation-mode CORDIC on a binary angle, one iteration a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mko_cordic
    import mko_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] angle,
    output logic             done,
    output logic signed [ANG_W-1:0] cos_out,
    output logic signed [ANG_W-1:0] sin_out
);

    localparam logic [CIDX_W-1:0] LAST = CIDX_W'(CORDIC_N);

    logic signed [ANG_W-1:0] x_reg, x_next;
    logic signed [ANG_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic [CIDX_W-1:0]       i_reg, i_next;
    logic                    flip_reg, flip_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [31:0]             a_rot;
    logic [31:0]             a_fold;
    logic signed [ANG_W-1:0] x_sh;
    logic signed [ANG_W-1:0] y_sh;
    logic signed [ANG_W-1:0] atan_ext;

    // Fold the angle into the right half plane, then rotate
    always_comb
    begin
        a_rot     = angle + 32'h4000_0000;
        a_fold    = a_rot[31] ? (angle - 32'h8000_0000) : angle;
        x_sh      = x_reg >>> i_reg;
        y_sh      = y_reg >>> i_reg;
        atan_ext  = $signed({2'b00, atan_bam(i_reg)});
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = $signed(CORDIC_GAIN);
            y_next    = '0;
            z_next    = $signed({{(ANG_W-32){a_fold[31]}}, a_fold});
            i_next    = '0;
            flip_next = a_rot[31];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (i_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (!z_reg[ANG_W-1])
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_ext;
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_ext;
                end
                i_next = i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

`default_nettype wire

/* sv/mko_dpath.sv */
// ---------------------------------------------------------------------------
// mko_dpath: kinematics and odometry datapath
// Configuration and state registers, operand selection for the shared
// multiplier, divider and CORDIC, and write-back of each step.
// ---------------------------------------------------------------------------
`default_nettype none

module mko_dpath
    import mko_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic signed [DATA_W-1:0] cmd_vx,
    input  wire logic signed [DATA_W-1:0] cmd_vy,
    input  wire logic signed [DATA_W-1:0] cmd_omega,
    input  wire logic signed [DATA_W-1:0] meas_lf,
    input  wire logic signed [DATA_W-1:0] meas_rf,
    input  wire logic signed [DATA_W-1:0] meas_lb,
    input  wire logic signed [DATA_W-1:0] meas_rb,
    input  wire logic [TIME_W-1:0]        time_us,
    input  wire dp_cmd_t                  cmd,
    output dp_stat_t                      stat,
    output logic signed [DATA_W-1:0]      drive_lf,
    output logic signed [DATA_W-1:0]      drive_rf,
    output logic signed [DATA_W-1:0]      drive_lb,
    output logic signed [DATA_W-1:0]      drive_rb,
    output logic signed [DATA_W-1:0]      pose_x,
    output logic signed [DATA_W-1:0]      pose_y,
    output logic [DATA_W-1:0]             pose_heading,
    output logic signed [DATA_W-1:0]      body_vx,
    output logic signed [DATA_W-1:0]      body_omega
);

    // Configuration
    logic [CFG_W-1:0] radius_reg, base_reg, track_reg;

    // Latched request
    logic signed [DATA_W-1:0] vx_in_reg, vy_in_reg, om_in_reg;
    logic signed [DATA_W-1:0] lf_reg, rf_reg, lb_reg, rb_reg;
    logic [TIME_W-1:0]        time_reg;

    // Architectural state
    logic signed [DATA_W-1:0] wheel_reg [4];
    logic signed [DATA_W-1:0] px_reg, py_reg, evx_reg, evy_reg, eom_reg;
    logic [DATA_W-1:0]        hd_reg;
    logic [TIME_W-1:0]        prev_reg;

    // Scratch
    logic signed [WIDE_W-1:0] s_reg, pa_reg, wx_reg, wy_reg;
    logic [WIDE_W-1:0]        tmp_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [ANG_W-1:0]  cos_reg, sin_reg;

    // Result registers
    logic signed [DATA_W-1:0] o_lf_reg, o_rf_reg, o_lb_reg, o_rb_reg;
    logic signed [DATA_W-1:0] o_px_reg, o_py_reg, o_vx_reg, o_om_reg;
    logic [DATA_W-1:0]        o_hd_reg;

    // Unit hookup
    logic [WIDE_W-1:0]        mul_a, mul_b, div_n;
    logic [DEN_W-1:0]         div_d;
    logic                     neg;
    logic [PROD_W-1:0]        mul_p;
    logic [WIDE_W-1:0]        div_q;
    logic                     mul_done, div_done, cor_done, mul_busy, div_busy;
    logic signed [ANG_W-1:0]  cor_cos, cor_sin;
    unit_t                    unit;

    // Derived values
    logic [CFG_W-1:0]         r_eff;
    logic [CFG_W:0]           bt_sum, bt_eff;
    logic signed [WIDE_W-1:0] vx64, vy64, om64, lf64, rf64, lb64, rb64;
    logic signed [WIDE_W-1:0] num0, num1, num2, num3;
    logic signed [WIDE_W-1:0] sum1, sum2, sum3;
    logic signed [WIDE_W-1:0] evx64, evy64, eom64, cos64, sin64;
    logic signed [PROD_W-1:0] prod_s, sh_f1, sh_f2, sh_30;
    logic signed [WIDE_W-1:0] quot_s;
    logic [WIDE_W-1:0]        recip_q;
    logic signed [WIDE_W-1:0] recip_s;
    logic [TIME_W-1:0]        dt_raw;
    logic [DT_W-1:0]          dt_clamp;
    logic [DATA_W-1:0]        hd_delta;

    always_comb
    begin
        r_eff  = (radius_reg == '0) ? CFG_W'(1) : radius_reg;
        bt_sum = {1'b0, base_reg} + {1'b0, track_reg};
        bt_eff = (bt_sum == '0) ? (CFG_W+1)'(1) : bt_sum;
        vx64   = WIDE_W'(vx_in_reg);
        vy64   = WIDE_W'(vy_in_reg);
        om64   = WIDE_W'(om_in_reg);
        lf64   = WIDE_W'(lf_reg);
        rf64   = WIDE_W'(rf_reg);
        lb64   = WIDE_W'(lb_reg);
        rb64   = WIDE_W'(rb_reg);
        num0   = vx64 - vy64 - s_reg;
        num1   = vx64 + vy64 + s_reg;
        num2   = vx64 + vy64 - s_reg;
        num3   = vx64 - vy64 + s_reg;
        sum1   = lf64 + rf64 + lb64 + rb64;
        sum2   = rf64 + lb64 - lf64 - rb64;
        sum3   = rf64 + rb64 - lf64 - lb64;
        evx64  = WIDE_W'(evx_reg);
        evy64  = WIDE_W'(evy_reg);
        eom64  = WIDE_W'(eom_reg);
        cos64  = WIDE_W'(cos_reg);
        sin64  = WIDE_W'(sin_reg);
        dt_raw = time_reg - prev_reg;
        dt_clamp = (dt_raw > DT_MAX) ? DT_MAX[DT_W-1:0] : dt_raw[DT_W-1:0];
    end

    // Operand selection per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = {{(DEN_W-CFG_W){1'b0}}, r_eff};
        neg   = 1'b0;
        case (cmd.step)
            ST_S:
            begin
                mul_a = mag64(om64);
                mul_b = WIDE_W'(bt_eff);
                neg   = om64[WIDE_W-1];
            end
            ST_W0:
            begin
                div_n = mag64(num0) << FRAC_BITS;
                neg   = num0[WIDE_W-1];
            end
            ST_W1:
            begin
                div_n = mag64(num1) << FRAC_BITS;
                neg   = num1[WIDE_W-1];
            end
            ST_W2:
            begin
                div_n = mag64(num2) << FRAC_BITS;
                neg   = num2[WIDE_W-1];
            end
            ST_W3:
            begin
                div_n = mag64(num3) << FRAC_BITS;
                neg   = num3[WIDE_W-1];
            end
            ST_VX:
            begin
                mul_a = WIDE_W'(r_eff);
                mul_b = mag64(sum1);
                neg   = sum1[WIDE_W-1];
            end
            ST_VY:
            begin
                mul_a = WIDE_W'(r_eff);
                mul_b = mag64(sum2);
                neg   = sum2[WIDE_W-1];
            end
            ST_OMM:
            begin
                mul_a = WIDE_W'(r_eff);
                mul_b = mag64(sum3);
                neg   = sum3[WIDE_W-1];
            end
            ST_OMD:
            begin
                div_n = tmp_reg;
                div_d = {{(DEN_W-CFG_W-2){1'b0}}, bt_eff, 1'b0};
                neg   = sum3[WIDE_W-1];
            end
            ST_XA:
            begin
                mul_a = mag64(evx64);
                mul_b = mag64(cos64);
                neg   = evx64[WIDE_W-1] ^ cos64[WIDE_W-1];
            end
            ST_XB:
            begin
                mul_a = mag64(evy64);
                mul_b = mag64(sin64);
                neg   = evy64[WIDE_W-1] ^ sin64[WIDE_W-1];
            end
            ST_YA:
            begin
                mul_a = mag64(evx64);
                mul_b = mag64(sin64);
                neg   = evx64[WIDE_W-1] ^ sin64[WIDE_W-1];
            end
            ST_YB:
            begin
                mul_a = mag64(evy64);
                mul_b = mag64(cos64);
                neg   = evy64[WIDE_W-1] ^ cos64[WIDE_W-1];
            end
            ST_PXM:
            begin
                mul_a = mag64(wx_reg);
                mul_b = WIDE_W'(dt_reg);
            end
            // distance over one million by reciprocal multiply
            ST_PXD:
            begin
                mul_a = tmp_reg;
                mul_b = RECIP_US;
                neg   = wx_reg[WIDE_W-1];
            end
            ST_PYM:
            begin
                mul_a = mag64(wy_reg);
                mul_b = WIDE_W'(dt_reg);
            end
            ST_PYD:
            begin
                mul_a = tmp_reg;
                mul_b = RECIP_US;
                neg   = wy_reg[WIDE_W-1];
            end
            ST_HM:
            begin
                mul_a = mag64(eom64);
                mul_b = WIDE_W'(dt_reg);
            end
            ST_HC:
            begin
                mul_a = tmp_reg;
                mul_b = RAD_US_TO_BAM;
                neg   = eom64[WIDE_W-1];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Signed results
    always_comb
    begin
        prod_s   = neg ? -$signed(mul_p) : $signed(mul_p);
        sh_f1    = prod_s >>> (FRAC_BITS + 1);
        sh_f2    = prod_s >>> (FRAC_BITS + 2);
        sh_30    = prod_s >>> 30;
        quot_s   = neg ? -$signed(div_q) : $signed(div_q);
        recip_q  = WIDE_W'(mul_p[PROD_W-1:RECIP_SH]);
        recip_s  = neg ? -$signed(recip_q) : $signed(recip_q);
        hd_delta = mul_p[32+FRAC_BITS +: DATA_W];
    end

    assign unit = step_unit(cmd.step);

    mko_muldiv u_muldiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_mul (cmd.start && (unit == U_MUL)),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_p     (mul_p),
        .mul_done  (mul_done),
        .mul_busy  (mul_busy),
        .start_div (cmd.start && (unit == U_DIV)),
        .div_n     (div_n),
        .div_d     (div_d),
        .div_q     (div_q),
        .div_done  (div_done),
        .div_busy  (div_busy)
    );

    mko_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start && (unit == U_COR)),
        .angle   (hd_reg),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    assign stat.done     = mul_done | div_done | cor_done;
    assign stat.mul_busy = mul_busy;
    assign stat.div_busy = div_busy;

    // Configuration and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            base_reg   <= BASE_RST;
            track_reg  <= TRACK_RST;
            for (int k = 0; k < 4; k++)
                wheel_reg[k] <= '0;
            px_reg   <= '0;
            py_reg   <= '0;
            hd_reg   <= '0;
            prev_reg <= '0;
            evx_reg  <= '0;
            evy_reg  <= '0;
            eom_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_data;
                    REG_BASE:   base_reg   <= cfg_data;
                    REG_TRACK:  track_reg  <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.wb)
            begin
                case (cmd.step)
                    ST_W0:  wheel_reg[0] <= sat32(quot_s);
                    ST_W1:  wheel_reg[1] <= sat32(quot_s);
                    ST_W2:  wheel_reg[2] <= sat32(quot_s);
                    ST_W3:  wheel_reg[3] <= sat32(quot_s);
                    ST_VX:
                    begin
                        evx_reg  <= sat32(sh_f2[WIDE_W-1:0]);
                        prev_reg <= time_reg;
                    end
                    ST_VY:  evy_reg <= sat32(sh_f2[WIDE_W-1:0]);
                    ST_OMD: eom_reg <= sat32(quot_s);
                    ST_PXD: px_reg  <= sat32(WIDE_W'(px_reg) + recip_s);
                    ST_PYD: py_reg  <= sat32(WIDE_W'(py_reg) + recip_s);
                    ST_HC:  hd_reg  <= neg ? (hd_reg - hd_delta) : (hd_reg + hd_delta);
                    default: ;
                endcase
            end
        end
    end

    // Request latch, scratch and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            vx_in_reg <= cmd_vx;
            vy_in_reg <= cmd_vy;
            om_in_reg <= cmd_omega;
            lf_reg    <= meas_lf;
            rf_reg    <= meas_rf;
            lb_reg    <= meas_lb;
            rb_reg    <= meas_rb;
            time_reg  <= time_us;
        end
        if (cmd.wb)
        begin
            case (cmd.step)
                ST_S:   s_reg   <= sh_f1[WIDE_W-1:0];
                ST_VX:  dt_reg  <= dt_clamp;
                ST_OMM: tmp_reg <= mul_p[WIDE_W-1:0];
                ST_COR:
                begin
                    cos_reg <= cor_cos;
                    sin_reg <= cor_sin;
                end
                ST_XA:  pa_reg  <= sh_30[WIDE_W-1:0];
                ST_XB:  wx_reg  <= pa_reg - sh_30[WIDE_W-1:0];
                ST_YA:  pa_reg  <= sh_30[WIDE_W-1:0];
                ST_YB:  wy_reg  <= pa_reg + sh_30[WIDE_W-1:0];
                ST_PXM: tmp_reg <= mul_p[WIDE_W-1:0];
                ST_PYM: tmp_reg <= mul_p[WIDE_W-1:0];
                ST_HM:  tmp_reg <= mul_p[WIDE_W-1:0];
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            o_lf_reg <= wheel_reg[0];
            o_rf_reg <= wheel_reg[1];
            o_lb_reg <= wheel_reg[2];
            o_rb_reg <= wheel_reg[3];
            o_px_reg <= px_reg;
            o_py_reg <= py_reg;
            o_hd_reg <= hd_reg;
            o_vx_reg <= evx_reg;
            o_om_reg <= eom_reg;
        end
    end

    assign drive_lf     = o_lf_reg;
    assign drive_rf     = o_rf_reg;
    assign drive_lb     = o_lb_reg;
    assign drive_rb     = o_rb_reg;
    assign pose_x       = o_px_reg;
    assign pose_y       = o_py_reg;
    assign pose_heading = o_hd_reg;
    assign body_vx      = o_vx_reg;
    assign body_omega   = o_om_reg;

endmodule

`default_nettype wire

/* sv/mko_ctrl.sv */
// ---------------------------------------------------------------------------
// mko_ctrl: step sequencer
// Accepts a request, walks its list of steps on the shared units and
// hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mko_ctrl
    import mko_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire logic     kind,
    output logic          out_valid,
    input  wire logic     out_stall,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    ctrl_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    logic        out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.load_in  = 1'b0;
        cmd.start    = 1'b0;
        cmd.wb       = 1'b0;
        cmd.load_out = 1'b0;
        cmd.step     = step_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    step_next   = kind ? ST_VX : ST_S;
                    state_next  = C_ISSUE;
                end
            end
            C_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = C_WAIT;
            end
            C_WAIT:
            begin
                if (stat.done)
                begin
                    cmd.wb = 1'b1;
                    if (step_last(step_reg))
                        state_next = C_OUT;
                    else
                    begin
                        step_next  = step_succ(step_reg);
                        state_next = C_ISSUE;
                    end
                end
            end
            C_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase

        // Output slot
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            step_reg      <= ST_S;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != C_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* sv/mecanum_kinematics_odometry.sv */
// ---------------------------------------------------------------------------
// mecanum_kinematics_odometry: mecanum chassis kinematics and odometry
// Inverse kinematics for velocity commands, forward kinematics and
// dead-reckoned pose for control ticks.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | in        | in_valid / in_stall  | kind, cmd_*, meas_*, time_us
//  out     | out       | out_valid / out_stall| drive_*, pose_*, body_*
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
//  One request at a time. The serial multiplier (one bit a cycle, also used
//  for the reciprocal divide by one million), the serial restoring divider
//  and the 24-step CORDIC are shared by all steps of a request.
//  Reset clears the pose, estimates and wheel commands and loads the default
//  geometry; no clearing pass is needed.
//  A finished result waits in the output register while out_stall is high;
//  a new request may be taken meanwhile, and its result waits until the slot
//  frees.
// ---------------------------------------------------------------------------
`default_nettype none

module mecanum_kinematics_odometry
    import mko_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     kind,
    input  wire logic signed [DATA_W-1:0] cmd_vx,
    input  wire logic signed [DATA_W-1:0] cmd_vy,
    input  wire logic signed [DATA_W-1:0] cmd_omega,
    input  wire logic signed [DATA_W-1:0] meas_lf,
    input  wire logic signed [DATA_W-1:0] meas_rf,
    input  wire logic signed [DATA_W-1:0] meas_lb,
    input  wire logic signed [DATA_W-1:0] meas_rb,
    input  wire logic [TIME_W-1:0]        time_us,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      drive_lf,
    output logic signed [DATA_W-1:0]      drive_rf,
    output logic signed [DATA_W-1:0]      drive_lb,
    output logic signed [DATA_W-1:0]      drive_rb,
    output logic signed [DATA_W-1:0]      pose_x,
    output logic signed [DATA_W-1:0]      pose_y,
    output logic [DATA_W-1:0]             pose_heading,
    output logic signed [DATA_W-1:0]      body_vx,
    output logic signed [DATA_W-1:0]      body_omega
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mko_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    mko_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_vx       (cmd_vx),
        .cmd_vy       (cmd_vy),
        .cmd_omega    (cmd_omega),
        .meas_lf      (meas_lf),
        .meas_rf      (meas_rf),
        .meas_lb      (meas_lb),
        .meas_rb      (meas_rb),
        .time_us      (time_us),
        .cmd          (cmd),
        .stat         (stat),
        .drive_lf     (drive_lf),
        .drive_rf     (drive_rf),
        .drive_lb     (drive_lb),
        .drive_rb     (drive_rb),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .body_vx      (body_vx),
        .body_omega   (body_omega)
    );

    // A taken request blocks the input until its steps finish
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after request");

    // The shared multiplier and divider never run at the same time
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.mul_busy && stat.div_busy))
        else $error("multiplier and divider busy together");

    // A new result only comes out of a request in flight
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without request in flight");

endmodule

`default_nettype wire
